// ===== design/des_pkg.sv =====
// Shared constants, types and helper functions of the double exponential smoother.
`default_nettype none

package des_pkg;

    // Sample format: two's complement Q2.22 by default.
    localparam int SAMPLE_WIDTH  = 24;
    localparam int FRACTION_BITS = 22;

    // Smoothing constants are unsigned and hold values from zero up to one.
    localparam int CONST_WIDTH = FRACTION_BITS + 1;

    // Multiplier operands: an unsigned factor and a signed value one bit wider than a sample.
    localparam int MUL_B_WIDTH = SAMPLE_WIDTH + 1;
    localparam int PROD_WIDTH  = (CONST_WIDTH + 1) + MUL_B_WIDTH;

    // Width of the sum of two truncated products before saturation.
    localparam int SUM_WIDTH = SAMPLE_WIDTH + 2;

    localparam logic [CONST_WIDTH-1:0] ONE_C = CONST_WIDTH'(longint'(1) << FRACTION_BITS);
    localparam logic signed [SAMPLE_WIDTH-1:0] ONE_S =
        SAMPLE_WIDTH'(longint'(1) << FRACTION_BITS);

    localparam logic signed [SUM_WIDTH-1:0] SAT_MAX =
        SUM_WIDTH'((longint'(1) << (SAMPLE_WIDTH - 1)) - longint'(1));
    localparam logic signed [SUM_WIDTH-1:0] SAT_MIN =
        SUM_WIDTH'(-(longint'(1) << (SAMPLE_WIDTH - 1)));

    // Reset values: 0.15 and 0.3, rounded to the nearest code.
    localparam longint ALPHA_RESET_L = ((longint'(15) << FRACTION_BITS) + 50) / 100;
    localparam longint GAMMA_RESET_L = ((longint'(30) << FRACTION_BITS) + 50) / 100;
    localparam logic [CONST_WIDTH-1:0] ALPHA_RESET = CONST_WIDTH'(ALPHA_RESET_L);
    localparam logic [CONST_WIDTH-1:0] GAMMA_RESET = CONST_WIDTH'(GAMMA_RESET_L);

    // Configuration register indexes.
    localparam int CFG_IDX_WIDTH = 3;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_ALPHA_CONST  = CFG_IDX_WIDTH'(0);
    localparam logic [CFG_IDX_WIDTH-1:0] REG_GAMMA_CONST  = CFG_IDX_WIDTH'(1);
    localparam logic [CFG_IDX_WIDTH-1:0] REG_ALPHA_STREAM = CFG_IDX_WIDTH'(2);
    localparam logic [CFG_IDX_WIDTH-1:0] REG_GAMMA_STREAM = CFG_IDX_WIDTH'(3);

    // Datapath steps, one per clock cycle while a request runs; the finish step may wait.
    typedef enum logic [3:0] {
        ST_NONE,
        ST_SQ_A,
        ST_SQ_G,
        ST_FO_A,
        ST_FO_G,
        ST_AX,
        ST_BLEND,
        ST_TREND_OLD,
        ST_LEVEL,
        ST_TREND_NEW,
        ST_FINISH
    } t_step;

    typedef struct packed {
        logic  load;
        t_step step;
    } t_cmd;

    // Clip a signed stream factor to the range zero to one.
    function automatic logic [CONST_WIDTH-1:0] clip_unit(
        input logic signed [SAMPLE_WIDTH-1:0] r
    );
        logic [CONST_WIDTH-1:0] res;
        if (r < 0) begin
            res = '0;
        end else if (r > ONE_S) begin
            res = ONE_C;
        end else begin
            res = r[CONST_WIDTH-1:0];
        end
        return res;
    endfunction

    // Clip an unsigned register factor to at most one.
    function automatic logic [CONST_WIDTH-1:0] clip_const(input logic [CONST_WIDTH-1:0] c);
        return (c > ONE_C) ? ONE_C : c;
    endfunction

    // Saturate a sum to the sample range.
    function automatic logic signed [SAMPLE_WIDTH-1:0] sat(
        input logic signed [SUM_WIDTH-1:0] v
    );
        logic signed [SAMPLE_WIDTH-1:0] res;
        if (v > SAT_MAX) begin
            res = SAT_MAX[SAMPLE_WIDTH-1:0];
        end else if (v < SAT_MIN) begin
            res = SAT_MIN[SAMPLE_WIDTH-1:0];
        end else begin
            res = v[SAMPLE_WIDTH-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== design/des_ctrl.sv =====
// Controller of the double exponential smoother: sequences the datapath steps.
`default_nettype none

module des_ctrl
    import des_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  wire  i_out_ready,
    output t_cmd o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state r_state;
    t_step  r_step;
    logic   r_out_valid;
    logic   s_slot_free;

    function automatic t_step next_step(input t_step s);
        t_step n;
        case (s)
            ST_SQ_A:      n = ST_SQ_G;
            ST_SQ_G:      n = ST_FO_A;
            ST_FO_A:      n = ST_FO_G;
            ST_FO_G:      n = ST_AX;
            ST_AX:        n = ST_BLEND;
            ST_BLEND:     n = ST_TREND_OLD;
            ST_TREND_OLD: n = ST_LEVEL;
            ST_LEVEL:     n = ST_TREND_NEW;
            ST_TREND_NEW: n = ST_FINISH;
            default:      n = ST_NONE;
        endcase
        return n;
    endfunction

    // The last step may only run once the previous result has left.
    assign s_slot_free = !r_out_valid || i_out_ready;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd.load = (r_state == S_IDLE) && i_in_valid;
        if (r_state == S_RUN && (r_step != ST_FINISH || s_slot_free)) begin
            o_cmd.step = r_step;
        end else begin
            o_cmd.step = ST_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= ST_NONE;
            r_out_valid <= 1'b0;
        end else begin
            // A finishing request refills the output in the cycle the old result leaves.
            if (r_state == S_RUN && r_step == ST_FINISH && s_slot_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_RUN;
                        r_step  <= ST_SQ_A;
                    end
                end
                S_RUN: begin
                    if (r_step == ST_FINISH) begin
                        if (s_slot_free) begin
                            r_state <= S_IDLE;
                            r_step  <= ST_NONE;
                        end
                    end else begin
                        r_step <= next_step(r_step);
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_step  <= ST_NONE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== design/des_dp.sv =====
// Datapath of the double exponential smoother: one shared multiplier and the state.
`default_nettype none

module des_dp
    import des_pkg::*;
(
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  t_cmd                            i_cmd,
    input  wire                             i_cfg_we,
    input  wire  [CFG_IDX_WIDTH-1:0]        i_cfg_idx,
    input  wire  [CONST_WIDTH-1:0]          i_cfg_data,
    input  wire  signed [SAMPLE_WIDTH-1:0]  i_sample,
    input  wire  signed [SAMPLE_WIDTH-1:0]  i_alpha_in,
    input  wire  signed [SAMPLE_WIDTH-1:0]  i_gamma_in,
    output logic signed [SAMPLE_WIDTH-1:0]  o_smoothed,
    output logic signed [SAMPLE_WIDTH-1:0]  o_trend
);

    localparam int ZPAD = MUL_B_WIDTH - CONST_WIDTH;

    // Configuration.
    logic [CONST_WIDTH-1:0] r_alpha_const;
    logic [CONST_WIDTH-1:0] r_gamma_const;
    logic                   r_alpha_stream;
    logic                   r_gamma_stream;

    // Working registers. The factor registers hold r, then r squared, then r to the fourth.
    logic        [CONST_WIDTH-1:0]   r_fa;
    logic        [CONST_WIDTH-1:0]   r_fg;
    logic signed [SAMPLE_WIDTH-1:0]  r_x;
    logic signed [PROD_WIDTH-1:0]    r_prod;
    logic signed [MUL_B_WIDTH-1:0]   r_p1;
    logic signed [MUL_B_WIDTH-1:0]   r_p2;
    logic signed [MUL_B_WIDTH-1:0]   r_p4;
    logic signed [SAMPLE_WIDTH-1:0]  r_lvl;

    // Kept state, which is also the result.
    logic signed [SAMPLE_WIDTH-1:0]  r_level;
    logic signed [SAMPLE_WIDTH-1:0]  r_trend;

    logic        [CONST_WIDTH-1:0]   s_ma;
    logic signed [MUL_B_WIDTH-1:0]   s_mb;
    logic                            s_mul_en;
    logic signed [PROD_WIDTH-1:0]    s_prod;
    logic signed [MUL_B_WIDTH-1:0]   s_shr;
    logic signed [SUM_WIDTH-1:0]     s_lvl_sum;
    logic signed [SUM_WIDTH-1:0]     s_trd_sum;

    // Truncated product: the arithmetic shift drops the fraction bits (floor).
    assign s_shr  = r_prod[FRACTION_BITS +: MUL_B_WIDTH];
    assign s_prod = $signed({1'b0, s_ma}) * s_mb;

    assign s_lvl_sum = {r_p1[MUL_B_WIDTH-1], r_p1} + {r_p2[MUL_B_WIDTH-1], r_p2};
    assign s_trd_sum = {r_p4[MUL_B_WIDTH-1], r_p4} + {s_shr[MUL_B_WIDTH-1], s_shr};

    always_comb begin
        s_ma     = r_fa;
        s_mb     = $signed({{ZPAD{1'b0}}, r_fa});
        s_mul_en = 1'b1;
        case (i_cmd.step)
            ST_SQ_A, ST_FO_A: begin
                s_ma = r_fa;
                s_mb = $signed({{ZPAD{1'b0}}, r_fa});
            end
            ST_SQ_G, ST_FO_G: begin
                s_ma = r_fg;
                s_mb = $signed({{ZPAD{1'b0}}, r_fg});
            end
            ST_AX: begin
                s_ma = r_fa;
                s_mb = {r_x[SAMPLE_WIDTH-1], r_x};
            end
            ST_BLEND: begin
                s_ma = ONE_C - r_fa;
                s_mb = {r_level[SAMPLE_WIDTH-1], r_level} + {r_trend[SAMPLE_WIDTH-1], r_trend};
            end
            ST_TREND_OLD: begin
                s_ma = ONE_C - r_fg;
                s_mb = {r_trend[SAMPLE_WIDTH-1], r_trend};
            end
            ST_TREND_NEW: begin
                s_ma = r_fg;
                s_mb = {r_lvl[SAMPLE_WIDTH-1], r_lvl} - {r_level[SAMPLE_WIDTH-1], r_level};
            end
            default: begin
                s_mul_en = 1'b0;
            end
        endcase
    end

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_const  <= ALPHA_RESET;
            r_gamma_const  <= GAMMA_RESET;
            r_alpha_stream <= 1'b0;
            r_gamma_stream <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ALPHA_CONST:  r_alpha_const  <= i_cfg_data;
                REG_GAMMA_CONST:  r_gamma_const  <= i_cfg_data;
                REG_ALPHA_STREAM: r_alpha_stream <= i_cfg_data[0];
                REG_GAMMA_STREAM: r_gamma_stream <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Smoothing state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
            r_trend <= '0;
        end else if (i_cmd.step == ST_FINISH) begin
            r_level <= r_lvl;
            r_trend <= sat(s_trd_sum);
        end
    end

    // Working registers; each product is collected in the step after the one that made it.
    always_ff @(posedge i_clk) begin
        if (s_mul_en) begin
            r_prod <= s_prod;
        end
        if (i_cmd.load) begin
            r_fa <= r_alpha_stream ? clip_unit(i_alpha_in) : clip_const(r_alpha_const);
            r_fg <= r_gamma_stream ? clip_unit(i_gamma_in) : clip_const(r_gamma_const);
            r_x  <= i_sample;
        end
        case (i_cmd.step)
            ST_SQ_G:      r_fa  <= s_shr[CONST_WIDTH-1:0];
            ST_FO_A:      r_fg  <= s_shr[CONST_WIDTH-1:0];
            ST_FO_G:      r_fa  <= s_shr[CONST_WIDTH-1:0];
            ST_AX:        r_fg  <= s_shr[CONST_WIDTH-1:0];
            ST_BLEND:     r_p1  <= s_shr;
            ST_TREND_OLD: r_p2  <= s_shr;
            ST_LEVEL: begin
                r_lvl <= sat(s_lvl_sum);
                r_p4  <= s_shr;
            end
            default: begin
            end
        endcase
    end

    assign o_smoothed = r_level;
    assign o_trend    = r_trend;

endmodule

`default_nettype wire

// ===== design/double_exponential_smoother.sv =====
// Top level of the double exponential smoother: controller, datapath and checks.
//
// Holt double exponential smoothing of a stream of signed Q2.22 samples.
// Each input request carries a sample and optional per-sample alpha and gamma
// factors; each one produces exactly one output request with the new level
// (o_smoothed) and the new trend (o_trend). Both channels use valid/ready.
// The configuration port is a plain write port: a register is written on any
// clock edge with i_cfg_we high. Index 0 is alpha_const, 1 gamma_const,
// 2 alpha_from_stream, 3 gamma_from_stream; other indexes are ignored.
// A new request is taken only while idle, after the previous one has left its
// finish step. The update runs in ten steps, one step a cycle except while the
// finish step waits: two for each fourth power and four for the blend and
// the trend share one multiplier, plus a saturation step and a finish step.
// The output registers hold the result until it is taken. If the receiver
// stalls, the next request is still accepted and worked on, and it waits in
// its finish step until the previous result is taken.
// Synchronous reset clears level and trend to zero and restores the register
// reset values (alpha 0.15, gamma 0.3, both factors from the registers).
`default_nettype none

module double_exponential_smoother
    import des_pkg::*;
(
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_in_valid,
    output logic                            o_in_ready,
    input  wire  signed [SAMPLE_WIDTH-1:0]  i_sample,
    input  wire  signed [SAMPLE_WIDTH-1:0]  i_alpha_in,
    input  wire  signed [SAMPLE_WIDTH-1:0]  i_gamma_in,
    output logic                            o_out_valid,
    input  wire                             i_out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]  o_smoothed,
    output logic signed [SAMPLE_WIDTH-1:0]  o_trend,
    input  wire                             i_cfg_we,
    input  wire  [CFG_IDX_WIDTH-1:0]        i_cfg_idx,
    input  wire  [CONST_WIDTH-1:0]          i_cfg_data
);

    t_cmd s_cmd;

    des_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (s_cmd)
    );

    des_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (s_cmd),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_sample   (i_sample),
        .i_alpha_in (i_alpha_in),
        .i_gamma_in (i_gamma_in),
        .o_smoothed (o_smoothed),
        .o_trend    (o_trend)
    );

    // A new request is never loaded while a step of the previous one runs.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.load |-> (s_cmd.step == ST_NONE))
        else $error("request loaded while the datapath is busy");

    // A result only appears after the finish step has updated the state.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(s_cmd.step == ST_FINISH))
        else $error("result valid without a finish step");

    // After a request is taken the block is busy on the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready stayed high after a request was taken");

endmodule

`default_nettype wire
